// ===== hw/rtl/tvbb_pkg.sv =====
// Shared types and constants for the transformed vertex bounding box unit.
// No dependencies; imported by tvbb_row and the top level.
`default_nettype none

package tvbb_pkg;

   // Signed fixed-point coordinate, 32 bits
   typedef logic signed [31:0] q_type;

   localparam q_type Q_MAX = 32'sh7FFF_FFFF;
   localparam q_type Q_MIN = 32'sh8000_0000;

   localparam int NUM_AXES = 3;
   localparam int NUM_REGS = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0_XY = 3'd0,
      CSR_ROW0_ZT = 3'd1,
      CSR_ROW1_XY = 3'd2,
      CSR_ROW1_ZT = 3'd3,
      CSR_ROW2_XY = 3'd4,
      CSR_ROW2_ZT = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tvbb_row.sv =====
// One matrix row of the vertex transform: three products plus translation,
// rounded and saturated over three register stages. Depends on tvbb_pkg.
`default_nettype none

module tvbb_row #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic           clock,
   input  wire logic           advance,
   input  wire logic [63:0]    coef_xy,
   input  wire logic [63:0]    coef_zt,
   input  wire tvbb_pkg::q_type pos_x,
   input  wire tvbb_pkg::q_type pos_y,
   input  wire tvbb_pkg::q_type pos_z,
   output tvbb_pkg::q_type     coord
);
   import tvbb_pkg::*;

   // Three 64-bit products and a shifted translation fit in 66 bits
   localparam int SUM_W = 66;
   localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(1) <<< (FRAC_BITS - 1);

   logic signed [63:0]      prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [63:0]      prod_x_in, prod_y_in, prod_z_in;
   q_type                   trans_ff;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] shifted;
   q_type                   coord_ff, coord_in;

   always_comb begin
      prod_x_in = $signed(coef_xy[31:0])  * pos_x;
      prod_y_in = $signed(coef_xy[63:32]) * pos_y;
      prod_z_in = $signed(coef_zt[31:0])  * pos_z;
   end

   always_comb begin
      sum_in = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff) + SUM_W'(prod_z_ff)
             + (SUM_W'(trans_ff) <<< FRAC_BITS) + HALF_LSB;
   end

   // Round-half-up is the floor of the biased sum
   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      if (shifted > SUM_W'(Q_MAX)) begin
         coord_in = Q_MAX;
      end else if (shifted < SUM_W'(Q_MIN)) begin
         coord_in = Q_MIN;
      end else begin
         coord_in = q_type'(shifted[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         trans_ff  <= $signed(coef_zt[63:32]);
         sum_ff    <= sum_in;
         coord_ff  <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/transformed_vertex_bounding_box_unit.sv =====
// Top level of the transformed vertex bounding box unit: input stage,
// three tvbb_row transforms, bound tracking and result register. Uses tvbb_pkg.
`default_nettype none

// Each accepted vertex is transformed by the 3x4 affine matrix in the six
// 64-bit registers (first coefficient in the low half) and folded into the
// running per-axis min/max. A vertex with last set closes the model: its
// bounds are presented on rsp_* and the running bounds return to their
// extremes. One vertex is taken every cycle while req_ready is high; after
// its last vertex is accepted it passes the input register, the product,
// sum and round/saturate registers and the bound fold before rsp_valid
// rises. req_ready drops only while a last vertex sits at the fold stage
// and the previous result has not been taken yet.
// Matrix registers may be written only while no vertex is in flight.
module transformed_vertex_bounding_box_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Vertex input
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire tvbb_pkg::q_type                   req_pos_x,
   input  wire tvbb_pkg::q_type                   req_pos_y,
   input  wire tvbb_pkg::q_type                   req_pos_z,
   input  wire logic                              req_last,
   // Bounds result
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output tvbb_pkg::q_type                        rsp_min_x,
   output tvbb_pkg::q_type                        rsp_min_y,
   output tvbb_pkg::q_type                        rsp_min_z,
   output tvbb_pkg::q_type                        rsp_max_x,
   output tvbb_pkg::q_type                        rsp_max_y,
   output tvbb_pkg::q_type                        rsp_max_z,
   // Matrix register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [tvbb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tvbb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import tvbb_pkg::*;

   localparam logic [CSR_DATA_W-1:0] ONE = CSR_DATA_W'(1) << FRAC_BITS;

   logic [CSR_DATA_W-1:0] cfg_ff [NUM_REGS];

   // Pipeline control
   logic       advance;
   logic       fold_fire;
   logic [3:0] valid_ff;  // input, product, sum, coord stages
   logic [3:0] last_ff;

   q_type pos_x_ff, pos_y_ff, pos_z_ff;
   q_type coord    [NUM_AXES];
   q_type low_ff   [NUM_AXES];
   q_type high_ff  [NUM_AXES];
   q_type low_in   [NUM_AXES];
   q_type high_in  [NUM_AXES];
   q_type min_ff   [NUM_AXES];
   q_type max_ff   [NUM_AXES];
   logic  rsp_valid_ff;

   // Hold everything only when a closing vertex meets an untaken result
   assign advance   = !(valid_ff[3] && last_ff[3] && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;
   assign csr_ready = 1'b1;
   assign fold_fire = advance && valid_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_ROW0_XY] <= ONE;
         cfg_ff[CSR_ROW0_ZT] <= '0;
         cfg_ff[CSR_ROW1_XY] <= ONE << 32;
         cfg_ff[CSR_ROW1_ZT] <= '0;
         cfg_ff[CSR_ROW2_XY] <= '0;
         cfg_ff[CSR_ROW2_ZT] <= ONE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW0_XY, CSR_ROW0_ZT, CSR_ROW1_XY,
            CSR_ROW1_ZT, CSR_ROW2_XY, CSR_ROW2_ZT: begin
               cfg_ff[csr_index] <= csr_data;
            end
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff  <= {last_ff[2:0], req_last};
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_row
      tvbb_row #(
         .FRAC_BITS (FRAC_BITS)
      ) u_row (
         .clock   (clock),
         .advance (advance),
         .coef_xy (cfg_ff[2*a]),
         .coef_zt (cfg_ff[2*a+1]),
         .pos_x   (pos_x_ff),
         .pos_y   (pos_y_ff),
         .pos_z   (pos_z_ff),
         .coord   (coord[a])
      );
   end

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         low_in[a]  = (coord[a] < low_ff[a])  ? coord[a] : low_ff[a];
         high_in[a] = (coord[a] > high_ff[a]) ? coord[a] : high_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            low_ff[a]  <= Q_MAX;
            high_ff[a] <= Q_MIN;
         end
      end else if (fold_fire) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            low_ff[a]  <= last_ff[3] ? Q_MAX : low_in[a];
            high_ff[a] <= last_ff[3] ? Q_MIN : high_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fold_fire && last_ff[3]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            min_ff[a] <= low_in[a];
            max_ff[a] <= high_in[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fold_fire && last_ff[3]) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_min_x = min_ff[0];
   assign rsp_min_y = min_ff[1];
   assign rsp_min_z = min_ff[2];
   assign rsp_max_x = max_ff[0];
   assign rsp_max_y = max_ff[1];
   assign rsp_max_z = max_ff[2];

   // A closing vertex always raises rsp_valid on the result side
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      fold_fire && last_ff[3] |=> rsp_valid)
      else $error("closing vertex did not raise rsp_valid");

   // Bounds return to their extremes after a model closes
   a_bounds_cleared: assert property (@(posedge clock) disable iff (reset)
      fold_fire && last_ff[3] |=> low_ff[0] == Q_MAX && high_ff[2] == Q_MIN)
      else $error("bounds not cleared after closing vertex");

   // Input is held back only by an untaken result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready && valid_ff[3] && last_ff[3])
      else $error("req_ready low without a pending result");

   // A held result keeps its bounds
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(min_ff[1]) && $stable(max_ff[1]))
      else $error("result bounds changed while waiting");

endmodule

`default_nettype wire
